/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the decimal display formatter.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define SDDF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules clocked by i_clk with reset i_rst_n.
`define SDDF_ASSERT(label, prop, msg) \
    `SDDF_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* hw/rtl/sddf_pkg.sv */
// Package for the signed decimal display formatter: widths, display codes
// and the reciprocal used to divide by ten. No dependencies.
package sddf_pkg;

    localparam int DIGIT_COUNT_DEF = 8;

    localparam int MAG_W   = 32;
    localparam int POINT_W = 8;
    localparam int DIGIT_W = 4;
    localparam int REG_W   = 4;
    localparam int CODE_W  = 8;

    // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
    localparam logic [MAG_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    localparam logic [CODE_W-1:0] CODE_BLANK       = 8'h0F;
    localparam logic [CODE_W-1:0] CODE_MINUS       = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_POINT       = 8'h80;
    localparam logic [CODE_W-1:0] CODE_POINT_BLANK = 8'h8F;

endpackage

/* hw/rtl/signed_decimal_display_formatter.sv */
// Top level of the signed decimal display formatter: sign stage, digit
// pipeline and write sequencer. Uses sddf_pkg, sddf_digit_stage, sddf_serializer.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_number, i_point_byte
//   out     | output    | o_out_valid / i_out_stall  | o_digit_register, o_digit_code,
//           |           |                            | o_last
//
// Every value yields DIGIT_COUNT or DIGIT_COUNT + 1 writes, one per cycle while the
// output is not stalled; the sequencer, which takes a new value when idle or with
// the last write of the one before, is the limit. A value passes the sign stage,
// digit stages and sequencer to the output register. Reset is synchronous, active
// low, and clears only valid bits and sequencer state. A stall on the output freezes
// the sequencer and, once the pipeline backs up, raises o_in_stall; nothing is lost.
`include "assert_macros.svh"

module signed_decimal_display_formatter #(
    parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [sddf_pkg::MAG_W-1:0]   i_number,
    input  logic [sddf_pkg::POINT_W-1:0]    i_point_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sddf_pkg::REG_W-1:0]      o_digit_register,
    output logic [sddf_pkg::CODE_W-1:0]     o_digit_code,
    output logic                            o_last
);
    import sddf_pkg::*;

    // Stage k of these arrays is the state in front of the digit-k divider;
    // index DIGIT_COUNT holds a fully split value waiting for the sequencer.
    logic                             w_valid  [0:DIGIT_COUNT];
    logic [MAG_W-1:0]                 w_mag    [0:DIGIT_COUNT-1];
    logic                             w_neg    [0:DIGIT_COUNT];
    logic [POINT_W-1:0]               w_point  [0:DIGIT_COUNT];
    logic [DIGIT_COUNT*DIGIT_W-1:0]   w_digits [0:DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0]           w_nz     [0:DIGIT_COUNT];

    logic                             w_take;
    logic                             w_advance;

    logic                             r_valid0;
    logic [MAG_W-1:0]                 r_mag0;
    logic                             r_neg0;
    logic [POINT_W-1:0]               r_point0;

    // The whole pipeline moves as one: it advances whenever its tail is empty
    // or the sequencer takes the finished value this cycle.
    assign w_advance  = !w_valid[DIGIT_COUNT] || w_take;
    assign o_in_stall = !w_advance;

    // Sign stage: the magnitude is the unsigned 32-bit negation, so the most
    // negative input still yields a well defined (truncated) digit string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_advance) begin
            r_valid0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_neg0   <= i_number[MAG_W-1];
            r_mag0   <= i_number[MAG_W-1] ? (MAG_W'(0) - MAG_W'(i_number)) : MAG_W'(i_number);
            r_point0 <= i_point_byte;
        end
    end

    assign w_valid[0]  = r_valid0;
    assign w_mag[0]    = r_mag0;
    assign w_neg[0]    = r_neg0;
    assign w_point[0]  = r_point0;
    assign w_digits[0] = '0;
    assign w_nz[0]     = '0;

    // One divide-by-ten stage per display position.
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
        if (k == DIGIT_COUNT - 1) begin : g_tail
            sddf_digit_stage #(
                .DIGIT_COUNT (DIGIT_COUNT),
                .DIGIT_IDX   (k)
            ) u_stage (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_advance),
                .i_valid  (w_valid[k]),
                .i_mag    (w_mag[k]),
                .i_neg    (w_neg[k]),
                .i_point  (w_point[k]),
                .i_digits (w_digits[k]),
                .i_nz     (w_nz[k]),
                .o_valid  (w_valid[k+1]),
                .o_mag    (),
                .o_neg    (w_neg[k+1]),
                .o_point  (w_point[k+1]),
                .o_digits (w_digits[k+1]),
                .o_nz     (w_nz[k+1])
            );
        end else begin : g_mid
            sddf_digit_stage #(
                .DIGIT_COUNT (DIGIT_COUNT),
                .DIGIT_IDX   (k)
            ) u_stage (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_advance),
                .i_valid  (w_valid[k]),
                .i_mag    (w_mag[k]),
                .i_neg    (w_neg[k]),
                .i_point  (w_point[k]),
                .i_digits (w_digits[k]),
                .i_nz     (w_nz[k]),
                .o_valid  (w_valid[k+1]),
                .o_mag    (w_mag[k+1]),
                .o_neg    (w_neg[k+1]),
                .o_point  (w_point[k+1]),
                .o_digits (w_digits[k+1]),
                .o_nz     (w_nz[k+1])
            );
        end
    end

    // The sequencer decides blank, point and minus per position and drives
    // the output register, which holds a write while the downstream stall is raised.
    sddf_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_serializer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[DIGIT_COUNT]),
        .o_take           (w_take),
        .i_neg            (w_neg[DIGIT_COUNT]),
        .i_point          (w_point[DIGIT_COUNT]),
        .i_digits         (w_digits[DIGIT_COUNT]),
        .i_nz             (w_nz[DIGIT_COUNT]),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_digit_register (o_digit_register),
        .o_digit_code     (o_digit_code),
        .o_last           (o_last)
    );

    // Within one value, writes run without gaps and never step back a position.
    `SDDF_ASSERT(a_words_contiguous, (o_out_valid && !i_out_stall && !o_last) |=> (o_out_valid && (o_digit_register == $past(o_digit_register) || o_digit_register == $past(o_digit_register) + 4'd1)), "write sequence of a value broke or skipped")

    // The closing write of a value always lands on the highest position.
    `SDDF_ASSERT(a_last_position, (o_out_valid && o_last) |-> (o_digit_register == REG_W'(DIGIT_COUNT)), "last write not on the top position")

    // A repeated position is only ever the blank-with-point second write.
    `SDDF_ASSERT(a_repeat_is_point, (o_out_valid && !i_out_stall && !o_last) |=> (o_digit_register != $past(o_digit_register) || o_digit_code == CODE_POINT_BLANK), "repeated position without point blank code")

endmodule

/* hw/rtl/sddf_digit_stage.sv */
// One pipeline stage of the formatter: peels one decimal digit off the
// magnitude by reciprocal multiplication. Depends on sddf_pkg.
module sddf_digit_stage #(
    parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEF,
    parameter int DIGIT_IDX   = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_valid,
    input  logic [sddf_pkg::MAG_W-1:0]                i_mag,
    input  logic                                      i_neg,
    input  logic [sddf_pkg::POINT_W-1:0]              i_point,
    input  logic [DIGIT_COUNT*sddf_pkg::DIGIT_W-1:0]  i_digits,
    input  logic [DIGIT_COUNT-1:0]                    i_nz,
    output logic                                      o_valid,
    output logic [sddf_pkg::MAG_W-1:0]                o_mag,
    output logic                                      o_neg,
    output logic [sddf_pkg::POINT_W-1:0]              o_point,
    output logic [DIGIT_COUNT*sddf_pkg::DIGIT_W-1:0]  o_digits,
    output logic [DIGIT_COUNT-1:0]                    o_nz
);
    import sddf_pkg::*;

    logic [2*MAG_W-1:0]               w_prod;
    logic [MAG_W-1:0]                 w_quot;
    logic [MAG_W-1:0]                 w_times10;
    logic [MAG_W-1:0]                 w_rem;
    logic [DIGIT_COUNT*DIGIT_W-1:0]   n_digits;
    logic [DIGIT_COUNT-1:0]           n_nz;

    logic                             r_valid;
    logic [MAG_W-1:0]                 r_mag;
    logic                             r_neg;
    logic [POINT_W-1:0]               r_point;
    logic [DIGIT_COUNT*DIGIT_W-1:0]   r_digits;
    logic [DIGIT_COUNT-1:0]           r_nz;

    assign w_prod    = (2*MAG_W)'(i_mag) * (2*MAG_W)'(RECIP10);
    assign w_quot    = MAG_W'(w_prod >> RECIP_SHIFT);
    assign w_times10 = (w_quot << 3) + (w_quot << 1);
    assign w_rem     = i_mag - w_times10;

    always_comb begin
        n_digits = i_digits;
        n_nz     = i_nz;
        n_digits[DIGIT_IDX*DIGIT_W +: DIGIT_W] = w_rem[DIGIT_W-1:0];
        // A digit is shown only while some magnitude remains at this position.
        n_nz[DIGIT_IDX] = |i_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= w_quot;
            r_neg    <= i_neg;
            r_point  <= i_point;
            r_digits <= n_digits;
            r_nz     <= n_nz;
        end
    end

    assign o_valid  = r_valid;
    assign o_mag    = r_mag;
    assign o_neg    = r_neg;
    assign o_point  = r_point;
    assign o_digits = r_digits;
    assign o_nz     = r_nz;

endmodule

/* hw/rtl/sddf_serializer.sv */
// Write sequencer of the formatter: walks the digit positions of one value, emits
// one register write per cycle unless stalled into an output register. Uses sddf_pkg.
module sddf_serializer #(
    parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_take,
    input  logic                                      i_neg,
    input  logic [sddf_pkg::POINT_W-1:0]              i_point,
    input  logic [DIGIT_COUNT*sddf_pkg::DIGIT_W-1:0]  i_digits,
    input  logic [DIGIT_COUNT-1:0]                    i_nz,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [sddf_pkg::REG_W-1:0]                o_digit_register,
    output logic [sddf_pkg::CODE_W-1:0]               o_digit_code,
    output logic                                      o_last
);
    import sddf_pkg::*;

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    logic                             r_busy;
    logic [POS_W-1:0]                 r_pos;
    logic                             r_extra;
    logic                             r_minus;
    logic                             r_neg;
    logic [POINT_W-1:0]               r_point;
    logic [DIGIT_COUNT*DIGIT_W-1:0]   r_digits;
    logic [DIGIT_COUNT-1:0]           r_nz;

    logic                             r_o_valid;
    logic [REG_W-1:0]                 r_o_reg;
    logic [CODE_W-1:0]                r_o_code;
    logic                             r_o_last;

    logic [POINT_W-1:0]               w_pos8;
    logic                             w_out_free;
    logic                             w_emit;
    logic                             w_load;
    logic [CODE_W-1:0]                w_code;
    logic                             w_go_extra;
    logic                             w_use_minus;
    logic                             w_word_last;

    assign w_pos8     = POINT_W'(r_pos);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_emit     = r_busy && w_out_free;

    always_comb begin
        w_go_extra  = 1'b0;
        w_use_minus = 1'b0;
        if (r_extra) begin
            w_code = CODE_POINT_BLANK;
        end else if (r_nz[r_pos]) begin
            w_code = {{(CODE_W-DIGIT_W){1'b0}}, r_digits[r_pos*DIGIT_W +: DIGIT_W]};
            if (r_point[r_pos]) begin
                w_code = w_code | CODE_POINT;
            end
        end else if (w_pos8 <= r_point) begin
            w_code     = CODE_BLANK;
            w_go_extra = (w_pos8 == r_point);
        end else if (r_neg && !r_minus) begin
            w_code      = CODE_MINUS;
            w_use_minus = 1'b1;
        end else begin
            w_code = CODE_BLANK;
        end
    end

    assign w_word_last = (r_pos == POS_LAST) && !w_go_extra;
    assign w_load      = !r_busy || (w_emit && w_word_last);
    assign o_take      = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pos     <= '0;
            r_extra   <= 1'b0;
            r_minus   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy  <= i_valid;
                r_pos   <= '0;
                r_extra <= 1'b0;
                r_minus <= 1'b0;
            end else if (w_emit) begin
                r_extra <= w_go_extra;
                if (!w_go_extra) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (w_use_minus) begin
                    r_minus <= 1'b1;
                end
            end
            if (w_out_free) begin
                r_o_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_neg    <= i_neg;
            r_point  <= i_point;
            r_digits <= i_digits;
            r_nz     <= i_nz;
        end
        if (w_emit) begin
            r_o_reg  <= REG_W'(r_pos) + REG_W'(1);
            r_o_code <= w_code;
            r_o_last <= w_word_last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_digit_register = r_o_reg;
    assign o_digit_code     = r_o_code;
    assign o_last           = r_o_last;

endmodule
